// ===== src/fct_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, request types and helper functions for the frequency count table.
// Used by fct_engine and frequency_count_table_top; no other dependencies.
package fct_pkg;

    // Field widths of the stream payload.
    localparam int FUNC_BITS      = 2;
    localparam int OPND_BITS      = 16;
    localparam int OUT_TDATA_BITS = 8;

    // Store geometry. Keys and frequencies come from a 16-bit operand, so
    // neither store needs more than 16 address bits.
    localparam int KEY_BITS       = 16;
    localparam int COUNT_BITS     = 16;
    localparam int KEY_ADDR_BITS  = (KEY_BITS < OPND_BITS) ? KEY_BITS : OPND_BITS;
    localparam int HIST_ADDR_BITS = (COUNT_BITS < OPND_BITS) ? COUNT_BITS : OPND_BITS;
    localparam int HIST_BITS      = 17;
    localparam int CLR_BITS       = (KEY_ADDR_BITS > HIST_ADDR_BITS) ? KEY_ADDR_BITS
                                                                      : HIST_ADDR_BITS;

    // Operation codes carried in tuser.
    localparam logic [FUNC_BITS-1:0] OP_INSERT = 2'd0;
    localparam logic [FUNC_BITS-1:0] OP_DELETE = 2'd1;
    localparam logic [FUNC_BITS-1:0] OP_QUERY  = 2'd2;

    // Access request to the key count store.
    typedef struct packed {
        logic                     we;
        logic [KEY_ADDR_BITS-1:0] waddr;
        logic [COUNT_BITS-1:0]    wdata;
        logic                     re;
        logic [KEY_ADDR_BITS-1:0] raddr;
    } key_req_t;

    // Access request to the histogram store.
    typedef struct packed {
        logic                      we;
        logic [HIST_ADDR_BITS-1:0] waddr;
        logic [HIST_BITS-1:0]      wdata;
        logic                      re;
        logic [HIST_ADDR_BITS-1:0] raddr;
    } hist_req_t;

    // Query answer handed to the output register.
    typedef struct packed {
        logic valid;
        logic found;
    } result_t;

    // A count has a histogram entry when it is nonzero and addressable.
    function automatic logic hist_ok(input logic [COUNT_BITS-1:0] c);
        return (c != '0) && ((c >> HIST_ADDR_BITS) == '0);
    endfunction

endpackage

// ===== src/fct_ram.sv =====
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies; instantiated twice by the top level.
module fct_ram #(
    parameter int ADDR_BITS = 16,
    parameter int DATA_BITS = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [0:(2**ADDR_BITS)-1];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/fct_engine.sv =====
`timescale 1ns / 1ps
// Sequencer of the frequency count table: clearing sweep after reset and the
// read-modify-write of the key count and histogram stores. Depends on fct_pkg.
module fct_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [fct_pkg::FUNC_BITS-1:0]      in_func,
    input  logic [fct_pkg::OPND_BITS-1:0]      in_operand,
    output fct_pkg::key_req_t                  key_req,
    input  logic [fct_pkg::COUNT_BITS-1:0]     key_rdata,
    output fct_pkg::hist_req_t                 hist_req,
    input  logic [fct_pkg::HIST_BITS-1:0]      hist_rdata,
    input  logic                               out_free,
    output fct_pkg::result_t                   res
);
    import fct_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_KEY,
        ST_HSUB,
        ST_HADD,
        ST_QRES
    } state_t;

    state_t                  state_reg, state_next;
    logic [CLR_BITS-1:0]     clr_reg, clr_next;
    logic [FUNC_BITS-1:0]    func_reg, func_next;
    logic [OPND_BITS-1:0]    opnd_reg, opnd_next;
    logic [COUNT_BITS-1:0]   old_reg, old_next;
    logic [COUNT_BITS-1:0]   new_reg, new_next;
    logic [COUNT_BITS-1:0]   cnt_inc;
    logic [COUNT_BITS-1:0]   cnt_dec;

    assign cnt_inc  = key_rdata + 1'b1;
    assign cnt_dec  = key_rdata - 1'b1;
    assign in_ready = (state_reg == ST_IDLE);

    // Next-state and store access decode.
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        func_next  = func_reg;
        opnd_next  = opnd_reg;
        old_next   = old_reg;
        new_next   = new_reg;
        key_req    = '0;
        hist_req   = '0;
        res        = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Zero one entry of each store per cycle.
                key_req.we     = ((clr_reg >> KEY_ADDR_BITS) == '0);
                key_req.waddr  = clr_reg[KEY_ADDR_BITS-1:0];
                hist_req.we    = ((clr_reg >> HIST_ADDR_BITS) == '0);
                hist_req.waddr = clr_reg[HIST_ADDR_BITS-1:0];
                clr_next       = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next      = in_func;
                    opnd_next      = in_operand;
                    key_req.re     = 1'b1;
                    key_req.raddr  = in_operand[KEY_ADDR_BITS-1:0];
                    hist_req.re    = (in_func == OP_QUERY);
                    hist_req.raddr = in_operand[HIST_ADDR_BITS-1:0];
                    unique case (in_func) inside
                        OP_INSERT, OP_DELETE: state_next = ST_KEY;
                        OP_QUERY:             state_next = ST_QRES;
                        default:              state_next = ST_IDLE;
                    endcase
                end
            end

            ST_KEY:
            begin
                // Key count is in; update it and fetch the old count's entry.
                old_next       = key_rdata;
                hist_req.re    = 1'b1;
                hist_req.raddr = key_rdata[HIST_ADDR_BITS-1:0];
                key_req.waddr  = opnd_reg[KEY_ADDR_BITS-1:0];
                if (func_reg == OP_INSERT)
                begin
                    new_next      = cnt_inc;
                    key_req.wdata = cnt_inc;
                    key_req.we    = (key_rdata != '1);
                end
                else
                begin
                    new_next      = cnt_dec;
                    key_req.wdata = cnt_dec;
                    key_req.we    = (key_rdata != '0);
                end
                state_next = key_req.we ? ST_HSUB : ST_IDLE;
            end

            ST_HSUB:
            begin
                // Drop the key from its old count and fetch the new count's entry.
                hist_req.we    = hist_ok(old_reg) && (hist_rdata != '0);
                hist_req.waddr = old_reg[HIST_ADDR_BITS-1:0];
                hist_req.wdata = hist_rdata - 1'b1;
                hist_req.re    = 1'b1;
                hist_req.raddr = new_reg[HIST_ADDR_BITS-1:0];
                state_next     = ST_HADD;
            end

            ST_HADD:
            begin
                hist_req.we    = hist_ok(new_reg);
                hist_req.waddr = new_reg[HIST_ADDR_BITS-1:0];
                hist_req.wdata = hist_rdata + 1'b1;
                state_next     = ST_IDLE;
            end

            ST_QRES:
            begin
                // Wait for the output register to free up, then answer.
                if (out_free)
                begin
                    res.valid  = 1'b1;
                    res.found  = (opnd_reg != '0)
                              && ((opnd_reg >> HIST_ADDR_BITS) == '0)
                              && (hist_rdata != '0);
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State and request context registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        opnd_reg <= opnd_next;
        old_reg  <= old_next;
        new_reg  <= new_next;
    end

endmodule

// ===== src/frequency_count_table_top.sv =====
`timescale 1ns / 1ps
// Top level of the frequency count table: two store RAMs, the sequencer and
// the output register. Depends on fct_pkg, fct_ram and fct_engine.
//
// Requests enter on the s_axis channel: tuser carries the operation
// (insert key, delete key, query frequency), tdata the 16-bit operand.
// Only a query produces a response on the m_axis channel: tdata bit 0 is
// 1 when the queried count is nonzero and at least one key currently has
// exactly that count. Unused operation codes are accepted and dropped.
//
// An insert or delete that changes a count passes these steps in order:
// the key count read, the old count's histogram read, its write-back less
// one beside the new count's read, and that entry's write-back plus one.
// An ignored insert or delete ends after the key count read. A query reads
// its histogram entry with the key count, and its response is loaded into
// the output register once that register is free. After reset both
// stores are swept to zero, one entry per cycle, over all 2^16 = 65536
// entries with s_axis_tready low. While m_axis_tready is low a response
// waits in the output register; inserts and deletes are still taken, and
// a following query holds in the block until the register is free.
module frequency_count_table_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [fct_pkg::OPND_BITS-1:0]        s_axis_tdata,  // [15:0] operand
    input  logic [fct_pkg::FUNC_BITS-1:0]        s_axis_tuser,  // [1:0] func
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [fct_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata   // [0] found, [7:1] zero
);
    import fct_pkg::*;

    key_req_t                key_req;
    hist_req_t               hist_req;
    result_t                 res;
    logic [COUNT_BITS-1:0]   key_rdata;
    logic [HIST_BITS-1:0]    hist_rdata;
    logic                    out_free;
    logic                    out_valid_reg;
    logic                    found_reg;

    // Per-key count store.
    fct_ram #(
        .ADDR_BITS (KEY_ADDR_BITS),
        .DATA_BITS (COUNT_BITS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_req.we),
        .waddr (key_req.waddr),
        .wdata (key_req.wdata),
        .re    (key_req.re),
        .raddr (key_req.raddr),
        .rdata (key_rdata)
    );

    // Number of keys per count value.
    fct_ram #(
        .ADDR_BITS (HIST_ADDR_BITS),
        .DATA_BITS (HIST_BITS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_req.we),
        .waddr (hist_req.waddr),
        .wdata (hist_req.wdata),
        .re    (hist_req.re),
        .raddr (hist_req.raddr),
        .rdata (hist_rdata)
    );

    fct_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_func    (s_axis_tuser),
        .in_operand (s_axis_tdata),
        .key_req    (key_req),
        .key_rdata  (key_rdata),
        .hist_req   (hist_req),
        .hist_rdata (hist_rdata),
        .out_free   (out_free),
        .res        (res)
    );

    // Output register: free when empty or being taken this cycle.
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            found_reg <= res.found;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_BITS-1){1'b0}}, found_reg};

endmodule
